FILE: rtl/core/atpi_pkg.sv
// Shared constants and types for the altitude PI thrust controller.
`timescale 1ns / 1ps
`default_nettype none
package atpi_pkg;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int INTEGRAL_WIDTH_DEF = 48;
    localparam int FIELD_WIDTH        = 32;
    localparam int COS_WIDTH          = 16;
    localparam int DT_WIDTH           = 16;
    localparam int GAIN_WIDTH         = 31;
    localparam int FRAC_BITS          = 16;
    localparam int COS_FRAC           = 14;
    localparam int DIV_NUM_BITS       = 47;
    localparam int DIV_Q_BITS         = DIV_NUM_BITS + COS_FRAC;
    localparam int IN_TDATA_WIDTH     = 192;
    localparam int OUT_TDATA_WIDTH    = 32;
    localparam int CFG_IDX_WIDTH      = 3;
    localparam int CFG_DATA_WIDTH     = 32;
    localparam int GRAVITY_Q16        = 642908;

    localparam logic [GAIN_WIDTH-1:0] POS_GAIN_RST = 31'd0;
    localparam logic [GAIN_WIDTH-1:0] LIMIT_RST    = 31'd6553600;
    localparam logic [GAIN_WIDTH-1:0] MASS_RST     = 31'd32768;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_POS_GAIN = 3'd0,
        CFG_VEL_GAIN = 3'd1,
        CFG_INT_GAIN = 3'd2,
        CFG_DESCENT  = 3'd3,
        CFG_ASCENT   = 3'd4,
        CFG_MASS     = 3'd5
    } t_cfg_idx;
endpackage
`default_nettype wire

FILE: rtl/core/atpi_mul.sv
// Bit-serial signed-by-unsigned multiplier with floor shift by the fraction bits.
`timescale 1ns / 1ps
`default_nettype none
module atpi_mul #(
    parameter int AW = 48
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [AW-1:0]                  i_a,
    input  wire logic [atpi_pkg::GAIN_WIDTH-1:0]       i_b,
    output logic                                       o_done,
    output logic signed [AW+atpi_pkg::GAIN_WIDTH+1-atpi_pkg::FRAC_BITS:0] o_p
);
    import atpi_pkg::*;

    localparam int PM = AW + 1 + GAIN_WIDTH;
    localparam int PS = PM + 1;
    localparam int CW = $clog2(GAIN_WIDTH);

    logic [PM-1:0]         r_mag, r_acc;
    logic [GAIN_WIDTH-1:0] r_b;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_neg, r_done;
    logic signed [PS-1:0]  w_full;
    logic [AW:0]           w_mag;

    // Take the magnitude of the multiplicand, one bit wider than the multiplicand
    assign w_mag = i_a[AW-1] ? (~{i_a[AW-1], i_a} + 1'b1) : {1'b0, i_a};

    // Shift the multiplicand up and add it in on each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(GAIN_WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_neg <= i_a[AW-1];
            r_mag <= PM'(w_mag);
            r_acc <= '0;
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_mag;
            r_mag <= r_mag << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Apply sign, then drop fraction bits (floor)
    assign w_full = r_neg ? -signed'({1'b0, r_acc}) : signed'({1'b0, r_acc});
    assign o_p    = w_full[PS-1:FRAC_BITS];
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/core/atpi_div.sv
// Bit-serial restoring divider for thrust numerator over tilt cosine magnitude.
`timescale 1ns / 1ps
`default_nettype none
module atpi_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [atpi_pkg::DIV_NUM_BITS-1:0]  i_num,
    input  wire logic [atpi_pkg::COS_WIDTH-1:0]     i_den,
    output logic                                    o_done,
    output logic [atpi_pkg::DIV_Q_BITS-1:0]         o_q
);
    import atpi_pkg::*;

    localparam int CW = $clog2(DIV_Q_BITS);

    logic [DIV_Q_BITS-1:0] r_sh;
    logic [COS_WIDTH-1:0]  r_rem, r_den;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_done;
    logic [COS_WIDTH:0]    w_trial;
    logic                  w_fit;

    // Bring down one dividend bit and try one subtract
    assign w_trial = {r_rem, r_sh[DIV_Q_BITS-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DIV_Q_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_sh  <= {i_num, {COS_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? COS_WIDTH'(w_trial - {1'b0, r_den}) : w_trial[COS_WIDTH-1:0];
            r_sh  <= {r_sh[DIV_Q_BITS-2:0], w_fit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sh;
endmodule
`default_nettype wire

FILE: rtl/core/altitude_pi_thrust_control_top.sv
// Altitude PI thrust controller: sequencer, state and config around serial units.
//  channel  | dir | handshake             | payload
//  s_axis   | in  | s_axis_tvalid/tready  | tdata: heights, climbs, cosine, ff, dt
//  m_axis   | out | m_axis_tvalid/tready  | tdata: thrust, tuser: fault
//  cfg      | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// One step runs five serial multiplies (start, a loop over the gain bits, done)
// and then one serial divide.
// A zero cosine or an oversized numerator skips the divide.
// The multiplier's loop takes one bit of the 31-bit gain per cycle.
// Reset clears the integrator and loads default register values.
// A result held on m_axis blocks the next request until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module altitude_pi_thrust_control_top #(
    parameter int VALUE_WIDTH    = atpi_pkg::VALUE_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = atpi_pkg::INTEGRAL_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // target_height, target_climb, measured_height, measured_climb,
    // tilt_cosine, feed_forward_accel, time_step
    input  wire logic [atpi_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // thrust
    output logic [atpi_pkg::OUT_TDATA_WIDTH-1:0]        m_axis_tdata,
    // fault
    output logic                                        m_axis_tuser,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [atpi_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [atpi_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);
    import atpi_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int IW = INTEGRAL_WIDTH;
    localparam int AW = (IW > W) ? IW : W;
    localparam int SW = AW + GAIN_WIDTH + 2 - FRAC_BITS;
    localparam int XW = SW + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic signed [FIELD_WIDTH-1:0] r_tc, n_tc, r_mc, n_mc, r_ff, n_ff;
    logic signed [COS_WIDTH-1:0] r_cos, n_cos;
    logic signed [W-1:0]  r_err, n_err, r_acc, n_acc;
    logic signed [IW-1:0] r_integ, n_integ;
    logic signed [AW-1:0] r_ma, n_ma;
    logic [GAIN_WIDTH-1:0] r_mb, n_mb;
    logic r_mstart, n_mstart, r_dstart, n_dstart;
    logic [DIV_NUM_BITS-1:0] r_dnum, n_dnum;
    logic [COS_WIDTH-1:0] r_dden, n_dden;
    logic r_neg, n_neg, r_fault, n_fault;
    logic [OUT_TDATA_WIDTH-1:0] r_thrust, n_thrust;
    logic [GAIN_WIDTH-1:0] r_pg, r_vg, r_ig, r_desc, r_asc, r_mass;

    logic m_done, d_done;
    logic signed [SW-1:0] m_p;
    logic [DIV_Q_BITS-1:0] d_q;
    logic w_in_acc;

    // Clamp a wide signed value to w bits
    function automatic logic signed [XW-1:0] sat_w(input logic signed [XW-1:0] x,
                                                   input int w);
        logic signed [XW-1:0] hi, lo;
        hi = signed'((XW'(1) << (w - 1)) - XW'(1));
        lo = ~hi;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    atpi_mul #(.AW(AW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_ma), .i_b(r_mb), .o_done(m_done), .o_p(m_p)
    );

    atpi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(d_done), .o_q(d_q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_thrust;
    assign m_axis_tuser  = r_fault;
    assign o_cfg_ready   = 1'b1;

    // Sequence the step through the serial units
    always_comb begin
        logic signed [XW-1:0] prod, t, v, dl, al, nm, un;
        logic big;
        n_state = r_state;  n_phase = r_phase;
        n_tc = r_tc; n_mc = r_mc; n_ff = r_ff; n_cos = r_cos;
        n_err = r_err; n_acc = r_acc; n_integ = r_integ;
        n_ma = r_ma; n_mb = r_mb; n_mstart = 1'b0; n_dstart = 1'b0;
        n_dnum = r_dnum; n_dden = r_dden; n_neg = r_neg;
        n_fault = r_fault; n_thrust = r_thrust;
        prod = XW'(m_p);
        dl   = -signed'(XW'(r_desc));
        al   = signed'(XW'(r_asc));
        t = '0; v = '0; nm = '0; un = '0; big = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    t = sat_w(XW'(signed'(s_axis_tdata[31:0]))
                              - XW'(signed'(s_axis_tdata[95:64])), W);
                    n_tc  = s_axis_tdata[63:32];
                    n_mc  = s_axis_tdata[127:96];
                    n_cos = s_axis_tdata[143:128];
                    n_ff  = s_axis_tdata[175:144];
                    n_err = t[W-1:0];
                    n_ma  = t[AW-1:0];
                    n_mb  = GAIN_WIDTH'(s_axis_tdata[191:176]);
                    n_mstart = 1'b1;
                    n_phase  = 3'd0;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                if (m_done) begin
                    n_mstart = 1'b1;
                    case (r_phase)
                        3'd0: begin
                            t = sat_w(XW'(r_integ) + sat_w(prod, IW), IW);
                            n_integ = t[IW-1:0];
                            n_ma = AW'(r_err);
                            n_mb = r_pg;
                        end
                        3'd1: begin
                            v = sat_w(sat_w(prod, W) + XW'(r_tc), W);
                            if (v < dl) v = dl;
                            if (v > al) v = al;
                            v = sat_w(v - XW'(r_mc), W);
                            n_ma = v[AW-1:0];
                            n_mb = r_vg;
                        end
                        3'd2: begin
                            t = sat_w(sat_w(prod, W) + XW'(r_ff), W);
                            n_acc = t[W-1:0];
                            n_ma = AW'(r_integ);
                            n_mb = r_ig;
                        end
                        3'd3: begin
                            t = sat_w(XW'(r_acc) + sat_w(prod, W), W);
                            t = sat_w(t - XW'(GRAVITY_Q16), W);
                            n_ma = t[AW-1:0];
                            n_mb = r_mass;
                        end
                        default: begin
                            // Numerator is minus acceleration times mass
                            n_mstart = 1'b0;
                            nm  = -prod;
                            un  = nm[XW-1] ? -nm : nm;
                            big = (un >> DIV_NUM_BITS) != '0;
                            n_neg = nm[XW-1] ^ r_cos[COS_WIDTH-1];
                            if (r_cos == '0) begin
                                n_thrust = nm[XW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                                n_fault  = 1'b1;
                                n_state  = S_OUT;
                            end else if (big) begin
                                n_thrust = n_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                                n_fault  = 1'b1;
                                n_state  = S_OUT;
                            end else begin
                                n_dnum   = un[DIV_NUM_BITS-1:0];
                                n_dden   = r_cos[COS_WIDTH-1] ? -r_cos : r_cos;
                                n_dstart = 1'b1;
                                n_state  = S_DIV;
                            end
                        end
                    endcase
                    n_phase = r_phase + 3'd1;
                end
            end
            S_DIV: begin
                if (d_done) begin
                    n_fault = 1'b0;
                    n_state = S_OUT;
                    if (r_neg) begin
                        if (d_q[DIV_Q_BITS-1:32] != '0 || (d_q[31] && d_q[30:0] != '0)) begin
                            n_thrust = 32'h8000_0000;
                            n_fault  = 1'b1;
                        end else begin
                            n_thrust = -d_q[31:0];
                        end
                    end else begin
                        if (d_q[DIV_Q_BITS-1:31] != '0) begin
                            n_thrust = 32'h7FFF_FFFF;
                            n_fault  = 1'b1;
                        end else begin
                            n_thrust = d_q[31:0];
                        end
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state, integrator, configuration and step data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            r_integ  <= '0;
            r_pg     <= POS_GAIN_RST;
            r_vg     <= POS_GAIN_RST;
            r_ig     <= POS_GAIN_RST;
            r_desc   <= LIMIT_RST;
            r_asc    <= LIMIT_RST;
            r_mass   <= MASS_RST;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_mstart <= n_mstart;
            r_dstart <= n_dstart;
            r_integ  <= n_integ;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POS_GAIN: r_pg   <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_VEL_GAIN: r_vg   <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_INT_GAIN: r_ig   <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_DESCENT:  r_desc <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_ASCENT:   r_asc  <= i_cfg_data[GAIN_WIDTH-1:0];
                    CFG_MASS:     r_mass <= i_cfg_data[GAIN_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
        r_tc <= n_tc; r_mc <= n_mc; r_ff <= n_ff; r_cos <= n_cos;
        r_err <= n_err; r_acc <= n_acc; r_ma <= n_ma; r_mb <= n_mb;
        r_dnum <= n_dnum; r_dden <= n_dden; r_neg <= n_neg;
        r_fault <= n_fault; r_thrust <= n_thrust;
    end

`ifndef NO_ASSERTIONS
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("request taken while result held");
    a_mul_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_done |-> r_state == S_MUL) else $error("multiply finished outside multiply phase");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_done |-> r_state == S_DIV) else $error("divide finished outside divide phase");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_mstart && r_state == S_MUL) else $error("request did not start step");
`endif
endmodule
`default_nettype wire
